// ===== rtl/rmq_pkg.sv =====
package rmq_pkg;

    // Diagonal axis selected for the root component
    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2,
        AXIS_W = 2'd3
    } axis_t;

endpackage

// ===== rtl/rotation_matrix_to_quaternion.sv =====
// Pipeline from input to output word: the stage 1 and stage 2 registers, the bit-per-stage root
// pipeline, the three bit-per-stage dividers in parallel, then the output register.
// Throughput: one word per cycle; a stall on the master side freezes every stage.
// Reset: rst_n clears all valid bits asynchronously; data registers are not reset.
module rotation_matrix_to_quaternion #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22 from the lowest bit up
    input  logic [((9*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // quat_w, quat_x, quat_y, quat_z from the lowest bit up
    output logic [((4*DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata
);
    import rmq_pkg::*;

    localparam int W     = DATA_WIDTH;
    localparam int OUT_W = ((4*W+7)/8)*8;
    localparam int RAD_W = W + 3;            // radicand, signed
    localparam int SQ_IN = 2 * (W + 2);      // rad << FRAC_BITS fits (FRAC_BITS < W)
    localparam int S_W   = W + 2;            // root width
    localparam int DF_W  = W + 1;            // signed difference width
    localparam int N_W   = DF_W + FRAC_BITS; // numerator magnitude width
    localparam int DEN_W = S_W + 1;          // 2*s
    localparam int TAG_W = 2 + 3 + 3 * DF_W; // axis, signs of the three diffs, magnitudes
    localparam int QV_W  = N_W + 1;

    // Stall everything together: the pipeline advances when the output can move.
    logic en;
    logic out_vld_reg;
    assign en            = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;

    // ---- stage 1: unpack, trace, axis choice ----
    logic signed [W-1:0] m [9];
    for (genvar g = 0; g < 9; g++)
    begin : g_unpack
        assign m[g] = s_axis_tdata[g*W +: W];
    end

    axis_t                  sel_next;
    logic signed [RAD_W-1:0] rad_next;
    logic signed [DF_W-1:0]  d0_next, d1_next, d2_next;
    logic signed [RAD_W-1:0] trace;

    always_comb
    begin
        trace = RAD_W'(m[0]) + RAD_W'(m[4]) + RAD_W'(m[8]);
        if (trace > 0)
        begin
            sel_next = AXIS_W;
            rad_next = trace + RAD_W'(1 << FRAC_BITS);
            d0_next  = DF_W'(m[7]) - DF_W'(m[5]);
            d1_next  = DF_W'(m[2]) - DF_W'(m[6]);
            d2_next  = DF_W'(m[3]) - DF_W'(m[1]);
        end
        else if (m[8] > ((m[4] > m[0]) ? m[4] : m[0]))
        begin
            // z largest: w from m10-m01, x from m20+m02, y from m21+m12
            sel_next = AXIS_Z;
            rad_next = RAD_W'(m[8]) - RAD_W'(m[0]) - RAD_W'(m[4]) + RAD_W'(1 << FRAC_BITS);
            d0_next  = DF_W'(m[3]) - DF_W'(m[1]);
            d1_next  = DF_W'(m[6]) + DF_W'(m[2]);
            d2_next  = DF_W'(m[7]) + DF_W'(m[5]);
        end
        else if (m[4] > m[0])
        begin
            // y largest: w from m02-m20, z from m21+m12, x from m01+m10
            sel_next = AXIS_Y;
            rad_next = RAD_W'(m[4]) - RAD_W'(m[8]) - RAD_W'(m[0]) + RAD_W'(1 << FRAC_BITS);
            d0_next  = DF_W'(m[2]) - DF_W'(m[6]);
            d1_next  = DF_W'(m[1]) + DF_W'(m[3]);
            d2_next  = DF_W'(m[7]) + DF_W'(m[5]);
        end
        else
        begin
            // x largest: w from m21-m12, y from m10+m01, z from m20+m02
            sel_next = AXIS_X;
            rad_next = RAD_W'(m[0]) - RAD_W'(m[4]) - RAD_W'(m[8]) + RAD_W'(1 << FRAC_BITS);
            d0_next  = DF_W'(m[7]) - DF_W'(m[5]);
            d1_next  = DF_W'(m[3]) + DF_W'(m[1]);
            d2_next  = DF_W'(m[6]) + DF_W'(m[2]);
        end
    end

    logic                    s1_vld_reg;
    axis_t                   s1_sel_reg;
    logic signed [RAD_W-1:0] s1_rad_reg;
    logic signed [DF_W-1:0]  s1_d_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (en)
            s1_vld_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_sel_reg  <= sel_next;
            s1_rad_reg  <= rad_next;
            s1_d_reg[0] <= d0_next;
            s1_d_reg[1] <= d1_next;
            s1_d_reg[2] <= d2_next;
        end
    end

    // ---- stage 2: clamp radicand, split differences into sign and magnitude ----
    logic                    s2_vld_reg;
    logic [SQ_IN-1:0]        s2_rad_reg;
    logic [TAG_W-1:0]        s2_tag_reg;
    logic [SQ_IN-1:0]        rad_sh;
    logic [TAG_W-1:0]        tag_next;
    logic [DF_W-1:0]         mag [3];

    always_comb
    begin
        if (s1_rad_reg > 0)
            rad_sh = SQ_IN'($unsigned(s1_rad_reg)) << FRAC_BITS;
        else
            rad_sh = '0;
        for (int i = 0; i < 3; i++)
            mag[i] = s1_d_reg[i][DF_W-1] ? DF_W'(-s1_d_reg[i]) : DF_W'(s1_d_reg[i]);
        tag_next = {s1_sel_reg, s1_d_reg[2][DF_W-1], s1_d_reg[1][DF_W-1],
                    s1_d_reg[0][DF_W-1], mag[2], mag[1], mag[0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else if (en)
            s2_vld_reg <= s1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_rad_reg <= rad_sh;
            s2_tag_reg <= tag_next;
        end
    end

    // ---- root pipeline ----
    logic             sq_vld;
    logic [S_W-1:0]   sq_root;
    logic [TAG_W-1:0] sq_tag;

    rmq_sqrt #(.IN_W(SQ_IN), .OUT_W(S_W), .TAG_W(TAG_W)) u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (s2_vld_reg),
        .rad     (s2_rad_reg),
        .in_tag  (s2_tag_reg),
        .out_vld (sq_vld),
        .root    (sq_root),
        .out_tag (sq_tag)
    );

    // ---- three dividers in parallel, sharing the denominator 2*s ----
    localparam int DT_W = TAG_W + S_W;
    logic [DEN_W-1:0] den;
    logic [N_W-1:0]   num [3];
    logic             dv_vld [3];
    logic [N_W-1:0]   quo [3];
    logic [DT_W-1:0]  dv_tag [3];

    assign den = {sq_root, 1'b0};

    for (genvar g = 0; g < 3; g++)
    begin : g_div
        assign num[g] = N_W'(sq_tag[g*DF_W +: DF_W]) << FRAC_BITS;
        rmq_div #(.N_W(N_W), .D_W(DEN_W), .TAG_W(DT_W)) u_div (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .in_vld  (sq_vld),
            .num     (num[g]),
            .den     (den),
            .in_tag  ({sq_root, sq_tag}),
            .out_vld (dv_vld[g]),
            .quo     (quo[g]),
            .out_tag (dv_tag[g])
        );
    end

    // ---- output stage: sign, zero-root case, route, saturate ----
    logic [S_W-1:0]          f_root;
    axis_t                   f_sel;
    logic signed [QV_W-1:0]  qv [3];
    logic signed [QV_W-1:0]  half;
    logic signed [QV_W-1:0]  cw, cx, cy, cz;
    logic [OUT_W-1:0]        data_next;
    logic [OUT_W-1:0]        data_reg;

    function automatic logic [W-1:0] sat(input logic signed [QV_W-1:0] v);
        logic signed [QV_W-1:0] hi;
        logic signed [QV_W-1:0] lo;
        hi = QV_W'((1 << (W - 1)) - 1);
        lo = -hi - QV_W'(1);
        if (v > hi)
            return hi[W-1:0];
        else if (v < lo)
            return lo[W-1:0];
        else
            return v[W-1:0];
    endfunction

    always_comb
    begin
        f_root = dv_tag[0][TAG_W +: S_W];
        f_sel  = axis_t'(dv_tag[0][TAG_W-1 -: 2]);
        for (int i = 0; i < 3; i++)
        begin
            if (f_root == '0)
                qv[i] = '0;
            else if (dv_tag[0][3*DF_W + i])
                qv[i] = -$signed({1'b0, quo[i]});
            else
                qv[i] = $signed({1'b0, quo[i]});
        end
        half = QV_W'(f_root >> 1);
        unique case (f_sel)
            AXIS_W:
            begin
                cw = half;  cx = qv[0]; cy = qv[1]; cz = qv[2];
            end
            AXIS_X:
            begin
                cw = qv[0]; cx = half;  cy = qv[1]; cz = qv[2];
            end
            AXIS_Y:
            begin
                cw = qv[0]; cx = qv[1]; cy = half;  cz = qv[2];
            end
            default:
            begin
                cw = qv[0]; cx = qv[1]; cy = qv[2]; cz = half;
            end
        endcase
        data_next = OUT_W'({sat(cz), sat(cy), sat(cx), sat(cw)});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= dv_vld[0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = data_reg;
endmodule

// ===== rtl/rmq_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module rmq_sqrt #(
    parameter int IN_W  = 34,
    parameter int OUT_W = 17,
    parameter int TAG_W = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_vld,
    input  logic [IN_W-1:0]  rad,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_vld,
    output logic [OUT_W-1:0] root,
    output logic [TAG_W-1:0] out_tag
);
    localparam int RW = 2 * OUT_W;

    logic [RW-1:0]    rem_reg  [OUT_W+1];
    logic [OUT_W-1:0] q_reg    [OUT_W+1];
    logic [TAG_W-1:0] tag_reg  [OUT_W+1];
    logic             vld_reg  [OUT_W+1];

    always_comb
    begin
        rem_reg[0] = RW'(rad);
        q_reg[0]   = '0;
        tag_reg[0] = in_tag;
        vld_reg[0] = in_vld;
    end

    for (genvar g = 0; g < OUT_W; g++)
    begin : g_stage
        localparam int B = OUT_W - 1 - g;
        logic [RW-1:0]    trial;
        logic [RW-1:0]    rem_next;
        logic [OUT_W-1:0] q_next;
        logic [RW-1:0]    rem_r;
        logic [OUT_W-1:0] q_r;
        logic [TAG_W-1:0] tag_r;
        logic             vld_r;

        always_comb
        begin
            // test (q << (b + 1)) + (1 << 2b), squared-difference form
            trial = ((RW'(q_reg[g]) << (B + 1)) | (RW'(1) << (2 * B)));
            if (rem_reg[g] >= trial)
            begin
                rem_next = rem_reg[g] - trial;
                q_next   = q_reg[g] | (OUT_W'(1) << B);
            end
            else
            begin
                rem_next = rem_reg[g];
                q_next   = q_reg[g];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_r <= 1'b0;
            else if (en)
                vld_r <= vld_reg[g];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_r <= rem_next;
                q_r   <= q_next;
                tag_r <= tag_reg[g];
            end
        end

        assign rem_reg[g+1] = rem_r;
        assign q_reg[g+1]   = q_r;
        assign tag_reg[g+1] = tag_r;
        assign vld_reg[g+1] = vld_r;
    end

    assign out_vld = vld_reg[OUT_W];
    assign root    = q_reg[OUT_W];
    assign out_tag = tag_reg[OUT_W];
endmodule

// ===== rtl/rmq_div.sv =====
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
module rmq_div #(
    parameter int N_W   = 48,
    parameter int D_W   = 18,
    parameter int TAG_W = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_vld,
    input  logic [N_W-1:0]   num,
    input  logic [D_W-1:0]   den,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_vld,
    output logic [N_W-1:0]   quo,
    output logic [TAG_W-1:0] out_tag
);
    localparam int RW = D_W + 1;

    logic [RW-1:0]    rem_s [N_W+1];
    logic [N_W-1:0]   num_s [N_W+1];
    logic [D_W-1:0]   den_s [N_W+1];
    logic [TAG_W-1:0] tag_s [N_W+1];
    logic             vld_s [N_W+1];

    always_comb
    begin
        rem_s[0] = '0;
        num_s[0] = num;
        den_s[0] = den;
        tag_s[0] = in_tag;
        vld_s[0] = in_vld;
    end

    for (genvar g = 0; g < N_W; g++)
    begin : g_stage
        logic [RW-1:0]    sh;
        logic [RW-1:0]    rem_next;
        logic [N_W-1:0]   num_next;
        logic [RW-1:0]    rem_r;
        logic [N_W-1:0]   num_r;
        logic [D_W-1:0]   den_r;
        logic [TAG_W-1:0] tag_r;
        logic             vld_r;

        always_comb
        begin
            // shift next numerator bit in; quotient bits fill from the bottom
            sh = {rem_s[g][RW-2:0], num_s[g][N_W-1]};
            num_next = {num_s[g][N_W-2:0], 1'b0};
            if (sh >= RW'(den_s[g]))
            begin
                rem_next    = sh - RW'(den_s[g]);
                num_next[0] = 1'b1;
            end
            else
                rem_next = sh;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_r <= 1'b0;
            else if (en)
                vld_r <= vld_s[g];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_r <= rem_next;
                num_r <= num_next;
                den_r <= den_s[g];
                tag_r <= tag_s[g];
            end
        end

        assign rem_s[g+1] = rem_r;
        assign num_s[g+1] = num_r;
        assign den_s[g+1] = den_r;
        assign tag_s[g+1] = tag_r;
        assign vld_s[g+1] = vld_r;
    end

    assign out_vld = vld_s[N_W];
    assign quo     = num_s[N_W];
    assign out_tag = tag_s[N_W];
endmodule

// ===== rtl/rmq_checker.sv =====
module rmq_checker #(
    parameter int TDATA_W = 64
) (
    input logic               clk,
    input logic               rst_n,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [TDATA_W-1:0] m_axis_tdata
);
    // stalled output word must hold
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed under stall");

    // input side is ready whenever output is free
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // input stalls whenever output stalls
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted while output stalled");
endmodule

bind rotation_matrix_to_quaternion rmq_checker #(.TDATA_W($bits(m_axis_tdata))) u_rmq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
